// ===== design/irsp_pkg.sv =====
package irsp_pkg;

   localparam int CORDIC_STEPS_DEF = 20;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_WIDTH       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_HEIGHT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION_DEGREES = 3'd5;
   localparam int CSR_DATA_W = 24;

   localparam int POINT_W = 20;
   localparam int SCALE_W = 24;
   localparam int ROT_W   = 17;
   localparam int OUT_W   = 22;

   localparam int CENT_W  = 23;   // 2*point - view
   localparam int COORD_W = 41;   // Q.16 working coordinates
   localparam int ANG_W   = 33;   // radians Q.30
   localparam int RES_W   = 14;   // residual degrees Q.7
   localparam int MAG_W   = 32;
   localparam int DIV_QBITS = 25;
   localparam int DIV_W   = 51;

   localparam logic [17:0] FULL_TURN_X1 = 18'd46080;
   localparam logic [17:0] FULL_TURN_X2 = 18'd92160;
   localparam logic [17:0] FULL_TURN_X3 = 18'd138240;
   localparam logic [15:0] QUARTER_X1   = 16'd11520;
   localparam logic [15:0] QUARTER_X2   = 16'd23040;
   localparam logic [15:0] QUARTER_X3   = 16'd34560;
   localparam logic [13:0] EIGHTH_Q7    = 14'd5760;
   localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
   localparam logic [29:0] GAIN_Q30     = 30'd652032874;
   localparam logic signed [26:0] OUT_MAX = 27'sd2097151;
   localparam logic signed [26:0] OUT_MIN = -27'sd2097152;

   function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0: v = 33'sd843314856;
         1: v = 33'sd497837829;
         2: v = 33'sd263043836;
         3: v = 33'sd133525158;
         4: v = 33'sd67021686;
         5: v = 33'sd33543515;
         6: v = 33'sd16775850;
         7: v = 33'sd8388437;
         8: v = 33'sd4194282;
         9: v = 33'sd2097149;
         10: v = 33'sd1048575;
         11: v = 33'sd524288;
         12: v = 33'sd262144;
         13: v = 33'sd131072;
         14: v = 33'sd65536;
         15: v = 33'sd32768;
         16: v = 33'sd16384;
         17: v = 33'sd8192;
         18: v = 33'sd4096;
         19: v = 33'sd2048;
         20: v = 33'sd1024;
         21: v = 33'sd512;
         22: v = 33'sd256;
         23: v = 33'sd128;
         24: v = 33'sd64;
         25: v = 33'sd32;
         26: v = 33'sd16;
         27: v = 33'sd8;
         28: v = 33'sd4;
         29: v = 33'sd2;
         30: v = 33'sd1;
         default: v = 33'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/irsp_front.sv =====
module irsp_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  logic [irsp_pkg::POINT_W-1:0]           point_x,
   input  logic [irsp_pkg::POINT_W-1:0]           point_y,
   input  logic [irsp_pkg::POINT_W-1:0]           view_width,
   input  logic [irsp_pkg::POINT_W-1:0]           view_height,
   input  logic signed [irsp_pkg::ROT_W-1:0]      rotation_degrees,
   output logic                                   out_valid,
   output logic signed [irsp_pkg::COORD_W-1:0]    x_out,
   output logic signed [irsp_pkg::COORD_W-1:0]    y_out,
   output logic signed [irsp_pkg::ANG_W-1:0]      z_out
);
   import irsp_pkg::*;

   // stage 1: centering and angle reduction
   logic                      v1_ff;
   logic signed [CENT_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]                quad_ff, quad_in;
   logic signed [RES_W-1:0]   res_ff, res_in;

   logic signed [18:0] wrap_s;
   logic [17:0]        wrap_u;
   logic [15:0]        am;
   logic [15:0]        rem;
   logic [1:0]         quad_raw;
   logic signed [14:0] res_neg;

   always_comb begin
      cx_in = $signed({2'b00, point_x, 1'b0}) - $signed({3'b000, view_width});
      cy_in = $signed({2'b00, point_y, 1'b0}) - $signed({3'b000, view_height});

      wrap_s = $signed({{2{rotation_degrees[ROT_W-1]}}, rotation_degrees}) + 19'sd92160;
      wrap_u = wrap_s[17:0];
      if (wrap_u >= FULL_TURN_X3) begin
         am = 16'(wrap_u - FULL_TURN_X3);
      end else if (wrap_u >= FULL_TURN_X2) begin
         am = 16'(wrap_u - FULL_TURN_X2);
      end else if (wrap_u >= FULL_TURN_X1) begin
         am = 16'(wrap_u - FULL_TURN_X1);
      end else begin
         am = wrap_u[15:0];
      end

      if (am >= QUARTER_X3) begin
         quad_raw = 2'd3;
         rem = am - QUARTER_X3;
      end else if (am >= QUARTER_X2) begin
         quad_raw = 2'd2;
         rem = am - QUARTER_X2;
      end else if (am >= QUARTER_X1) begin
         quad_raw = 2'd1;
         rem = am - QUARTER_X1;
      end else begin
         quad_raw = 2'd0;
         rem = am;
      end

      // upper half of a quarter goes to the next quarter with a negative residual
      res_neg = $signed({1'b0, rem[13:0]}) - 15'sd11520;
      if (rem[13:0] >= EIGHTH_Q7) begin
         quad_in = quad_raw + 2'd1;
         res_in = res_neg[13:0];
      end else begin
         quad_in = quad_raw;
         res_in = $signed(rem[13:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
      end
      if (ce) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         quad_ff <= quad_in;
         res_ff <= res_in;
      end
   end

   // stage 2: angle to radians, quarter-turn rotation
   logic                      v2_ff;
   logic signed [COORD_W-1:0] x2_ff, x2_in, y2_ff, y2_in;
   logic signed [ANG_W-1:0]   z2_ff, z2_in;
   logic signed [41:0]        ang_prod;
   logic signed [41:0]        ang_rnd;
   logic signed [COORD_W-1:0] xe, ye;

   always_comb begin
      ang_prod = res_ff * $signed({1'b0, DEG_TO_RAD_Q32});
      ang_rnd = (ang_prod + 42'sd256) >>> 9;
      z2_in = -ang_rnd[ANG_W-1:0];
      xe = {{2{cx_ff[CENT_W-1]}}, cx_ff, 16'b0};
      ye = {{2{cy_ff[CENT_W-1]}}, cy_ff, 16'b0};
      case (quad_ff)
         2'd1: begin
            x2_in = ye;
            y2_in = -xe;
         end
         2'd2: begin
            x2_in = -xe;
            y2_in = -ye;
         end
         2'd3: begin
            x2_in = -ye;
            y2_in = xe;
         end
         default: begin
            x2_in = xe;
            y2_in = ye;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ce) begin
         v2_ff <= v1_ff;
      end
      if (ce) begin
         x2_ff <= x2_in;
         y2_ff <= y2_in;
         z2_ff <= z2_in;
      end
   end

   assign out_valid = v2_ff;
   assign x_out = x2_ff;
   assign y_out = y2_ff;
   assign z_out = z2_ff;

endmodule

// ===== design/irsp_cordic.sv =====
module irsp_cordic #(
   parameter int CORDIC_STEPS = irsp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  logic signed [irsp_pkg::COORD_W-1:0]    x_in,
   input  logic signed [irsp_pkg::COORD_W-1:0]    y_in,
   input  logic signed [irsp_pkg::ANG_W-1:0]      z_in,
   output logic                                   out_valid,
   output logic signed [irsp_pkg::COORD_W-1:0]    x_out,
   output logic signed [irsp_pkg::COORD_W-1:0]    y_out
);
   import irsp_pkg::*;

   logic                      v_ff [0:CORDIC_STEPS-1];
   logic signed [COORD_W-1:0] x_ff [0:CORDIC_STEPS-1];
   logic signed [COORD_W-1:0] y_ff [0:CORDIC_STEPS-1];
   logic signed [ANG_W-1:0]   z_ff [0:CORDIC_STEPS-1];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic                      v_prev;
      logic signed [COORD_W-1:0] x_prev, y_prev, x_in_s, y_in_s, dx, dy;
      logic signed [ANG_W-1:0]   z_prev, z_in_s;

      if (i == 0) begin : g_first
         assign v_prev = in_valid;
         assign x_prev = x_in;
         assign y_prev = y_in;
         assign z_prev = z_in;
      end else begin : g_rest
         assign v_prev = v_ff[i-1];
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_comb begin
         dx = y_prev >>> i;
         dy = x_prev >>> i;
         if (!z_prev[ANG_W-1]) begin
            x_in_s = x_prev - dx;
            y_in_s = y_prev + dy;
            z_in_s = z_prev - atan_q30(i);
         end else begin
            x_in_s = x_prev + dx;
            y_in_s = y_prev - dy;
            z_in_s = z_prev + atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (ce) begin
            v_ff[i] <= v_prev;
         end
         if (ce) begin
            x_ff[i] <= x_in_s;
            y_ff[i] <= y_in_s;
            z_ff[i] <= z_in_s;
         end
      end
   end

   assign out_valid = v_ff[CORDIC_STEPS-1];
   assign x_out = x_ff[CORDIC_STEPS-1];
   assign y_out = y_ff[CORDIC_STEPS-1];

endmodule

// ===== design/irsp_scale_div.sv =====
module irsp_scale_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  logic signed [irsp_pkg::COORD_W-1:0]    x_in,
   input  logic signed [irsp_pkg::COORD_W-1:0]    y_in,
   input  logic [irsp_pkg::POINT_W-1:0]           normal_width,
   input  logic [irsp_pkg::POINT_W-1:0]           normal_height,
   input  logic [irsp_pkg::SCALE_W-1:0]           scale_factor,
   output logic                                   out_valid,
   output logic signed [irsp_pkg::OUT_W-1:0]      mapped_x,
   output logic signed [irsp_pkg::OUT_W-1:0]      mapped_y,
   output logic                                   clipped
);
   import irsp_pkg::*;

   logic [SCALE_W-1:0] dvs;
   logic [DIV_W-1:0]   dvs2;
   assign dvs  = (scale_factor == '0) ? SCALE_W'(1) : scale_factor;
   assign dvs2 = DIV_W'({dvs, 1'b0});

   // gain multiply
   logic                  vm_ff;
   logic signed [32:0]    m_ff [0:1];
   // divider stages, index 0 is the prep register (magnitude, numerator, overflow check)
   logic                  vd_ff  [0:DIV_QBITS];
   logic [DIV_W-1:0]      r_ff   [0:1][0:DIV_QBITS];
   logic [DIV_QBITS-1:0]  q_ff   [0:1][0:DIV_QBITS];
   logic                  neg_ff [0:1][0:DIV_QBITS];
   logic                  ovf_ff [0:1][0:DIV_QBITS];
   // output register
   logic                  vo_ff;
   logic signed [OUT_W-1:0] o_ff [0:1];
   logic                  sat_ff [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (ce) begin
         vm_ff <= in_valid;
         vo_ff <= vd_ff[DIV_QBITS];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff[0] <= 1'b0;
      end else if (ce) begin
         vd_ff[0] <= vm_ff;
      end
   end

   for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_vd
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (ce) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [COORD_W-1:0] src;
      logic [POINT_W-1:0]        nrm;
      logic signed [31:0]        xs;
      logic signed [62:0]        gprod;
      logic signed [32:0]        mneg;
      logic [MAG_W-1:0]          mag;
      logic [DIV_W-1:0]          numer;

      assign src = (l == 0) ? x_in : y_in;
      assign nrm = (l == 0) ? normal_width : normal_height;

      always_comb begin
         xs = src[COORD_W-1:9];
         gprod = xs * $signed({1'b0, GAIN_Q30});
         mneg = -m_ff[l];
         mag = m_ff[l][32] ? mneg[MAG_W-1:0] : m_ff[l][MAG_W-1:0];
         numer = DIV_W'({mag, 10'b0}) + DIV_W'(dvs);
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            m_ff[l] <= gprod[62:30];
            r_ff[l][0] <= numer;
            q_ff[l][0] <= '0;
            neg_ff[l][0] <= m_ff[l][32];
            ovf_ff[l][0] <= numer >= (dvs2 << DIV_QBITS);
         end
      end

      // restoring division, one quotient bit per stage
      for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_div
         logic [DIV_W-1:0] trial;
         logic             take;
         assign trial = dvs2 << (DIV_QBITS - k);
         assign take = r_ff[l][k-1] >= trial;
         always_ff @(posedge clock) begin
            if (ce) begin
               r_ff[l][k] <= take ? r_ff[l][k-1] - trial : r_ff[l][k-1];
               q_ff[l][k] <= {q_ff[l][k-1][DIV_QBITS-2:0], take};
               neg_ff[l][k] <= neg_ff[l][k-1];
               ovf_ff[l][k] <= ovf_ff[l][k-1];
            end
         end
      end

      logic [DIV_QBITS-1:0]      qm;
      logic signed [DIV_QBITS:0] qs;
      logic signed [26:0]        q9, q8;
      logic signed [OUT_W-1:0]   o_in;
      logic                      sat_in;

      always_comb begin
         qm = ovf_ff[l][DIV_QBITS] ? '1 : q_ff[l][DIV_QBITS];
         qs = neg_ff[l][DIV_QBITS] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
         q9 = 27'(qs) + $signed({7'b0, nrm});
         q8 = (q9 + 27'sd1) >>> 1;
         if (q8 > OUT_MAX) begin
            o_in = OUT_MAX[OUT_W-1:0];
            sat_in = 1'b1;
         end else if (q8 < OUT_MIN) begin
            o_in = OUT_MIN[OUT_W-1:0];
            sat_in = 1'b1;
         end else begin
            o_in = q8[OUT_W-1:0];
            sat_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            o_ff[l] <= o_in;
            sat_ff[l] <= sat_in;
         end
      end
   end

   assign out_valid = vo_ff;
   assign mapped_x = o_ff[0];
   assign mapped_y = o_ff[1];
   assign clipped = sat_ff[0] | sat_ff[1];

endmodule

// ===== design/inverse_rotate_scale_point.sv =====
// Channel  Dir  Handshake                    Payload (low bit first)
// req      in   req_tvalid / req_tready      tdata: point_x[19:0], point_y[39:20]
// rsp      out  rsp_tvalid / rsp_tready      tdata: mapped_x[21:0], mapped_y[43:22];
//                                            tuser: clipped
// csr      in   csr_valid / csr_ready        csr_index, csr_data
//
// One point per cycle while no result is held; the stages are two front stages,
// one per CORDIC iteration, a gain multiply, a divider prep stage, 25
// restoring-division stages and the output register.
// Synchronous active-high reset clears valid bits and sets configuration registers to defaults.
// A held result stalls the whole pipeline; nothing is dropped or duplicated.
module inverse_rotate_scale_point #(
   parameter int CORDIC_STEPS = irsp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,  // point_x, point_y
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // mapped_x, mapped_y, 4'b0
   output logic                              rsp_tuser,  // clipped
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [irsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [irsp_pkg::CSR_DATA_W-1:0]   csr_data
);
   import irsp_pkg::*;

   logic [POINT_W-1:0]       normal_width_ff, normal_height_ff;
   logic [POINT_W-1:0]       view_width_ff, view_height_ff;
   logic [SCALE_W-1:0]       scale_factor_ff;
   logic signed [ROT_W-1:0]  rotation_degrees_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_width_ff <= 20'd65536;
         normal_height_ff <= 20'd49152;
         view_width_ff <= 20'd65536;
         view_height_ff <= 20'd49152;
         scale_factor_ff <= 24'd65536;
         rotation_degrees_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_NORMAL_WIDTH:     normal_width_ff <= csr_data[POINT_W-1:0];
            REG_NORMAL_HEIGHT:    normal_height_ff <= csr_data[POINT_W-1:0];
            REG_VIEW_WIDTH:       view_width_ff <= csr_data[POINT_W-1:0];
            REG_VIEW_HEIGHT:      view_height_ff <= csr_data[POINT_W-1:0];
            REG_SCALE_FACTOR:     scale_factor_ff <= csr_data;
            REG_ROTATION_DEGREES: rotation_degrees_ff <= $signed(csr_data[ROT_W-1:0]);
            default: ;
         endcase
      end
   end

   logic ce;
   assign ce = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   logic                      f_valid, c_valid;
   logic signed [COORD_W-1:0] f_x, f_y, c_x, c_y;
   logic signed [ANG_W-1:0]   f_z;
   logic signed [OUT_W-1:0]   mapped_x, mapped_y;
   logic                      clipped;

   irsp_front u_front (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(req_tvalid),
      .point_x(req_tdata[19:0]), .point_y(req_tdata[39:20]),
      .view_width(view_width_ff), .view_height(view_height_ff),
      .rotation_degrees(rotation_degrees_ff),
      .out_valid(f_valid), .x_out(f_x), .y_out(f_y), .z_out(f_z)
   );

   irsp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(f_valid), .x_in(f_x), .y_in(f_y), .z_in(f_z),
      .out_valid(c_valid), .x_out(c_x), .y_out(c_y)
   );

   irsp_scale_div u_scale_div (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(c_valid), .x_in(c_x), .y_in(c_y),
      .normal_width(normal_width_ff), .normal_height(normal_height_ff),
      .scale_factor(scale_factor_ff),
      .out_valid(rsp_tvalid), .mapped_x(mapped_x), .mapped_y(mapped_y),
      .clipped(clipped)
   );

   assign rsp_tdata = {4'b0, mapped_y, mapped_x};
   assign rsp_tuser = clipped;

endmodule
